>>> hdl/fuzzy_name_match_scorer_macros.svh
// Assertion macros for the fuzzy name match scorer checker.
// No dependencies; included by the checker file only.
`ifndef FUZZY_NAME_MATCH_SCORER_MACROS_SVH
`define FUZZY_NAME_MATCH_SCORER_MACROS_SVH

// Checked only while out of reset.
`define FNMS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fnms assertion failed");

// Checked at every edge, reset included.
`define FNMS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("fnms assertion failed");

`endif

>>> hdl/fnms_pkg.sv
// Shared types, codes and constants of the fuzzy name match scorer.
// No dependencies.
package fnms_pkg;

    localparam int CHAR_W    = 8;
    localparam int QCHARS    = 32;
    localparam int QA_W      = 5;
    localparam int QLEN_W    = 6;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int SCORE_W   = 7;
    localparam int PEN_MAX   = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QLEN = 3'd0,
        CFG_QW0  = 3'd1,
        CFG_QW1  = 3'd2,
        CFG_QW2  = 3'd3,
        CFG_QW3  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_SUBSEQ = 3'd1,
        KIND_SUBSTR = 3'd2,
        KIND_WORD   = 3'd3,
        KIND_PREFIX = 3'd4,
        KIND_EXACT  = 3'd5
    } t_kind;

    localparam logic [SCORE_W-1:0] SCORE_NONE   = 7'd0;
    localparam logic [SCORE_W-1:0] SCORE_SUBSEQ = 7'd50;
    localparam logic [SCORE_W-1:0] SCORE_SUBSTR = 7'd65;
    localparam logic [SCORE_W-1:0] SCORE_WORD   = 7'd85;
    localparam logic [SCORE_W-1:0] SCORE_PREFIX = 7'd95;
    localparam logic [SCORE_W-1:0] SCORE_EXACT  = 7'd100;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFS   = 8'h20;

    typedef struct packed {
        logic [QLEN_W-1:0]             qlen;   // already limited to the query depth
        logic [QCHARS-1:0][CHAR_W-1:0] chars;  // case folded
    } t_query;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        t_kind              kind;
    } t_result;

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

endpackage

>>> hdl/fuzzy_name_match_scorer.sv
// Top level of the fuzzy name match scorer: input and result registers, handshakes.
// Depends on fnms_pkg, fnms_cfg and fnms_core.
//
// Usage: load the query through the write port (index 0 length, 1..4 character
// words, lowest character in the low byte) while no name is in flight. Stream
// the target name one character per transfer on the slave channel, tlast on
// its final character. One result per name leaves on the master channel:
// tdata holds the score, tuser the match kind.
// Throughput: one character per cycle while tready is high. A taken character is
// held in the input register and processed as it leaves; for the final character
// the edge that processes it also loads the result register, which drives the result.
// Non-final characters never wait on the master side. A final character waits
// in the input register only while an earlier result is still held by the
// receiver; tready drops for that time.
// Reset (synchronous, active low) clears the query, the per-name state and
// both valid flags.
module fuzzy_name_match_scorer #(
    parameter int MAX_QUERY  = 32,
    parameter int MAX_TARGET = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] target_char
    input  logic        i_s_tlast,   // is_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [6:0] score, [7] zero
    output logic [2:0]  o_m_tuser,   // [2:0] match_kind
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    logic                           r_in_valid, r_in_last;
    logic [fnms_pkg::CHAR_W-1:0]    r_in_char;
    logic                           r_out_valid;
    fnms_pkg::t_result              r_out_res;
    logic                           advance, out_load;
    fnms_pkg::t_query               query;
    fnms_pkg::t_result              result;

    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign out_load   = advance && r_in_last;
    assign o_s_tready = !r_in_valid || advance;

    fnms_cfg #(
        .MAX_QUERY (MAX_QUERY)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_query    (query)
    );

    fnms_core #(
        .MAX_QUERY  (MAX_QUERY),
        .MAX_TARGET (MAX_TARGET)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .i_query  (query),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_res <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_res.score};
    assign o_m_tuser  = r_out_res.kind;

endmodule

>>> hdl/fnms_cfg.sv
// Query registers: length and four 64-bit character words, folded for compare.
// Depends on fnms_pkg.
module fnms_cfg #(
    parameter int MAX_QUERY = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fnms_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fnms_pkg::CFG_W-1:0]         i_cfg_data,
    output fnms_pkg::t_query                   o_query
);

    logic [fnms_pkg::QLEN_W-1:0] r_qlen;
    logic [fnms_pkg::CFG_W-1:0]  r_qword [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= '0;
            for (int w = 0; w < 4; w++) begin
                r_qword[w] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (fnms_pkg::t_cfg_idx'(i_cfg_idx))
                fnms_pkg::CFG_QLEN: r_qlen     <= i_cfg_data[fnms_pkg::QLEN_W-1:0];
                fnms_pkg::CFG_QW0:  r_qword[0] <= i_cfg_data;
                fnms_pkg::CFG_QW1:  r_qword[1] <= i_cfg_data;
                fnms_pkg::CFG_QW2:  r_qword[2] <= i_cfg_data;
                fnms_pkg::CFG_QW3:  r_qword[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_query.qlen = (r_qlen > fnms_pkg::QLEN_W'(MAX_QUERY))
                        ? fnms_pkg::QLEN_W'(MAX_QUERY) : r_qlen;

    for (genvar j = 0; j < fnms_pkg::QCHARS; j++) begin : g_char
        assign o_query.chars[j] = fnms_pkg::fold(r_qword[j / 8][(j % 8) * 8 +: 8]);
    end

endmodule

>>> hdl/fnms_core.sv
// Per-character match state: window compare, prefix, subsequence and scoring.
// Depends on fnms_pkg.
module fnms_core #(
    parameter int MAX_QUERY  = 32,
    parameter int MAX_TARGET = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [fnms_pkg::CHAR_W-1:0]   i_char,
    input  logic                          i_last,
    input  fnms_pkg::t_query              i_query,
    output fnms_pkg::t_result             o_result
);

    localparam int WD  = MAX_QUERY + 1;
    localparam int QW  = $clog2(MAX_QUERY + 1);
    localparam int PW  = $clog2(MAX_TARGET + 1);
    localparam int CW  = ((PW > fnms_pkg::QLEN_W) ? PW : fnms_pkg::QLEN_W) + 1;
    localparam int SXW = QW + fnms_pkg::QA_W;
    localparam int PXW = PW + fnms_pkg::QA_W;

    logic [fnms_pkg::CHAR_W-1:0] r_win [WD];
    logic [fnms_pkg::CHAR_W-1:0] n_win [WD];
    logic [PW-1:0] r_pos, r_first, r_lastm;
    logic [QW-1:0] r_sidx;
    logic          r_pfx_ok, r_sub_found, r_sub_space;

    logic [fnms_pkg::CHAR_W-1:0] c, pfx_char, seq_char;
    logic [CW-1:0]  qlen_c, pos_c, len_c, span_c, pen, pen_cl;
    logic [QW-1:0]  qlen_q;
    logic [PXW-1:0] pos_x;
    logic [SXW-1:0] sidx_x;
    logic           q_active, pfx_miss, sub_try, sub_hit, space_hit, seq_hit, sub_new;
    logic [MAX_QUERY-1:0] win_hit;
    logic [PW-1:0]  u_pos, u_first, u_lastm, span;
    logic [QW-1:0]  u_sidx;
    logic           u_pfx, u_found, u_space;

    assign c        = fnms_pkg::fold(i_char);
    assign qlen_c   = CW'(i_query.qlen);
    assign qlen_q   = QW'(i_query.qlen);
    assign q_active = (qlen_c != '0);
    assign pos_c    = CW'(r_pos);

    always_comb begin
        n_win[0] = c;
        for (int k = 1; k < WD; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    // prefix
    assign pos_x    = PXW'(r_pos);
    assign pfx_char = i_query.chars[pos_x[fnms_pkg::QA_W-1:0]];
    assign pfx_miss = (pos_c < qlen_c) && (c != pfx_char);

    // window compare, query aligned to the newest character
    always_comb begin
        logic [CW-1:0] diff;
        diff = '0;
        for (int k = 0; k < MAX_QUERY; k++) begin
            diff       = qlen_c - CW'(1) - CW'(k);
            win_hit[k] = (CW'(k) >= qlen_c)
                      || (n_win[k] == i_query.chars[diff[fnms_pkg::QA_W-1:0]]);
        end
    end

    assign sub_hit   = &win_hit;
    assign sub_try   = !r_sub_found && ((pos_c + CW'(1)) >= qlen_c);
    assign space_hit = (pos_c >= qlen_c) && (n_win[qlen_q] == fnms_pkg::CHAR_SPACE);
    assign sub_new   = q_active && sub_try && sub_hit;

    // greedy subsequence
    assign sidx_x   = SXW'(r_sidx);
    assign seq_char = i_query.chars[sidx_x[fnms_pkg::QA_W-1:0]];
    assign seq_hit  = q_active && (CW'(r_sidx) < qlen_c) && (c == seq_char);

    assign u_pfx   = r_pfx_ok && !(q_active && pfx_miss);
    assign u_found = r_sub_found || sub_new;
    assign u_space = sub_new ? space_hit : r_sub_space;
    assign u_sidx  = seq_hit ? QW'(r_sidx + 1'b1) : r_sidx;
    assign u_first = (seq_hit && r_sidx == '0) ? r_pos : r_first;
    assign u_lastm = seq_hit ? r_pos : r_lastm;
    assign u_pos   = (r_pos < PW'(MAX_TARGET)) ? PW'(r_pos + 1'b1) : r_pos;

    // scoring on the updated state
    assign len_c  = CW'(u_pos);
    assign span   = u_lastm - u_first;
    assign span_c = CW'(span);
    assign pen    = (span_c > qlen_c) ? (span_c - qlen_c) : '0;
    assign pen_cl = (pen > CW'(fnms_pkg::PEN_MAX)) ? CW'(fnms_pkg::PEN_MAX) : pen;

    always_comb begin
        o_result.score = fnms_pkg::SCORE_NONE;
        o_result.kind  = fnms_pkg::KIND_NONE;
        priority if (!q_active) begin
            o_result.score = fnms_pkg::SCORE_NONE;
            o_result.kind  = fnms_pkg::KIND_NONE;
        end else if (u_pfx && len_c == qlen_c) begin
            o_result.score = fnms_pkg::SCORE_EXACT;
            o_result.kind  = fnms_pkg::KIND_EXACT;
        end else if (u_pfx && len_c > qlen_c) begin
            o_result.score = fnms_pkg::SCORE_PREFIX;
            o_result.kind  = fnms_pkg::KIND_PREFIX;
        end else if (u_found && u_space) begin
            o_result.score = fnms_pkg::SCORE_WORD;
            o_result.kind  = fnms_pkg::KIND_WORD;
        end else if (u_found) begin
            o_result.score = fnms_pkg::SCORE_SUBSTR;
            o_result.kind  = fnms_pkg::KIND_SUBSTR;
        end else if (CW'(u_sidx) == qlen_c) begin
            o_result.score = fnms_pkg::SCORE_SUBSEQ - fnms_pkg::SCORE_W'(pen_cl);
            o_result.kind  = fnms_pkg::KIND_SUBSEQ;
        end else begin
            o_result.score = fnms_pkg::SCORE_NONE;
            o_result.kind  = fnms_pkg::KIND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_first     <= '0;
            r_lastm     <= '0;
            r_sidx      <= '0;
            r_pfx_ok    <= 1'b1;
            r_sub_found <= 1'b0;
            r_sub_space <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_pos       <= '0;
                r_first     <= '0;
                r_lastm     <= '0;
                r_sidx      <= '0;
                r_pfx_ok    <= 1'b1;
                r_sub_found <= 1'b0;
                r_sub_space <= 1'b0;
            end else begin
                r_pos       <= u_pos;
                r_first     <= u_first;
                r_lastm     <= u_lastm;
                r_sidx      <= u_sidx;
                r_pfx_ok    <= u_pfx;
                r_sub_found <= u_found;
                r_sub_space <= u_space;
            end
        end
    end

    // window entries older than the current name are never read
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_win <= n_win;
        end
    end

endmodule

>>> hdl/fnms_checker.sv
// Port-level checks of the fuzzy name match scorer, bound to the top level.
// Depends on fnms_pkg and fuzzy_name_match_scorer_macros.svh.
`include "fuzzy_name_match_scorer_macros.svh"

module fnms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic [2:0]  o_m_tuser
);

    localparam logic [7:0] SUBSEQ_MIN = 8'(fnms_pkg::SCORE_SUBSEQ - fnms_pkg::PEN_MAX);
    localparam logic [7:0] SUBSEQ_MAX = {1'b0, fnms_pkg::SCORE_SUBSEQ};

    logic        m_stall;
    logic [10:0] m_word;
    logic        score_ok;

    assign m_stall = o_m_tvalid && !i_m_tready;
    assign m_word  = {o_m_tdata, o_m_tuser};

    always_comb begin
        unique case (fnms_pkg::t_kind'(o_m_tuser))
            fnms_pkg::KIND_NONE:   score_ok = (o_m_tdata == {1'b0, fnms_pkg::SCORE_NONE});
            fnms_pkg::KIND_SUBSEQ: begin
                score_ok = (o_m_tdata >= SUBSEQ_MIN) && (o_m_tdata <= SUBSEQ_MAX);
            end
            fnms_pkg::KIND_SUBSTR: score_ok = (o_m_tdata == {1'b0, fnms_pkg::SCORE_SUBSTR});
            fnms_pkg::KIND_WORD:   score_ok = (o_m_tdata == {1'b0, fnms_pkg::SCORE_WORD});
            fnms_pkg::KIND_PREFIX: score_ok = (o_m_tdata == {1'b0, fnms_pkg::SCORE_PREFIX});
            fnms_pkg::KIND_EXACT:  score_ok = (o_m_tdata == {1'b0, fnms_pkg::SCORE_EXACT});
            default:               score_ok = 1'b0;
        endcase
    end

    `FNMS_ASSERT_ALWAYS(a_reset_drops_valid, i_clk, !i_rst_n |=> !o_m_tvalid)

    `FNMS_ASSERT(a_out_hold, i_clk, i_rst_n, m_stall |=> (o_m_tvalid && $stable(m_word)))

    `FNMS_ASSERT(a_stall_only_on_full, i_clk, i_rst_n, !o_s_tready |-> m_stall)

    `FNMS_ASSERT(a_score_fits_kind, i_clk, i_rst_n, o_m_tvalid |-> score_ok)

endmodule

bind fuzzy_name_match_scorer fnms_checker u_fnms_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

>>> dv/fuzzy_name_match_scorer_checker.sv
// Scoreboard for the fuzzy name match scorer: tracks query writes and name characters,
// predicts the score of each finished name and checks it against the result channel.
// Depends on fnms_pkg.
`timescale 1ns / 1ps
module fuzzy_name_match_scorer_checker #(
    parameter int MAX_QUERY  = 32,
    parameter int MAX_TARGET = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] target_char
    input  logic        i_s_tlast,   // is_last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [6:0] score, [7] zero
    input  logic [2:0]  i_m_tuser,   // [2:0] match_kind
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output int          o_errors,
    output int          o_outstanding
);

    logic [7:0]        win [0:MAX_QUERY];   // folded chars, newest at 0
    int                pos;
    int                sq_idx;
    int                first_pos;
    int                last_pos;
    bit                pfx_ok;
    bit                sub_found;
    bit                sub_space;
    logic [5:0]        q_len;
    logic [63:0]       q_words [4];
    fnms_pkg::t_result expected_scores [$];

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    endfunction

    function automatic logic [7:0] query_char(input int j);
        int k;
        k = j % 32;
        return lower(q_words[k / 8][(k % 8) * 8 +: 8]);
    endfunction

    task automatic clear_name();
        for (int k = 0; k <= MAX_QUERY; k++) win[k] = '0;
        pos       = 0;
        pfx_ok    = 1'b1;
        sub_found = 1'b0;
        sub_space = 1'b0;
        sq_idx    = 0;
        first_pos = 0;
        last_pos  = 0;
    endtask

    task automatic take_char(input logic [7:0] raw, input logic is_last);
        logic [7:0]        c;
        int                ql;
        int                i;
        int                span;
        int                pen;
        bit                ok;
        fnms_pkg::t_result r;
        c  = lower(raw);
        ql = (q_len > MAX_QUERY) ? MAX_QUERY : int'(q_len);
        i  = pos;
        for (int k = MAX_QUERY; k > 0; k--) win[k] = win[k - 1];
        win[0] = c;
        if (ql > 0) begin
            if (pfx_ok && i < ql && c != query_char(i)) pfx_ok = 1'b0;
            if (!sub_found && i + 1 >= ql) begin
                ok = 1'b1;
                for (int j = 0; j < ql; j++) begin
                    if (query_char(j) != win[ql - 1 - j]) ok = 1'b0;
                end
                if (ok) begin
                    sub_found = 1'b1;
                    sub_space = (i >= ql) && (win[ql] == fnms_pkg::CHAR_SPACE);
                end
            end
            if (sq_idx < ql && c == query_char(sq_idx)) begin
                if (sq_idx == 0) first_pos = i;
                last_pos = i;
                sq_idx++;
            end
        end
        if (pos < MAX_TARGET) pos++;
        if (is_last) begin
            r.score = fnms_pkg::SCORE_NONE;
            r.kind  = fnms_pkg::KIND_NONE;
            if (ql > 0) begin
                if (pfx_ok && pos == ql) begin
                    r.score = fnms_pkg::SCORE_EXACT;
                    r.kind  = fnms_pkg::KIND_EXACT;
                end else if (pfx_ok && pos > ql) begin
                    r.score = fnms_pkg::SCORE_PREFIX;
                    r.kind  = fnms_pkg::KIND_PREFIX;
                end else if (sub_found) begin
                    r.score = sub_space ? fnms_pkg::SCORE_WORD : fnms_pkg::SCORE_SUBSTR;
                    r.kind  = sub_space ? fnms_pkg::KIND_WORD : fnms_pkg::KIND_SUBSTR;
                end else if (sq_idx == ql) begin
                    span = last_pos - first_pos;
                    pen  = (span > ql) ? span - ql : 0;
                    if (pen > fnms_pkg::PEN_MAX) pen = fnms_pkg::PEN_MAX;
                    r.score = fnms_pkg::SCORE_SUBSEQ - fnms_pkg::SCORE_W'(pen);
                    r.kind  = fnms_pkg::KIND_SUBSEQ;
                end
            end
            expected_scores = {expected_scores, r};
            clear_name();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            q_len = '0;
            for (int w = 0; w < 4; w++) q_words[w] = '0;
            clear_name();
            expected_scores.delete();
            o_errors      = 0;
            o_outstanding = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fnms_pkg::CFG_QLEN: q_len      = i_cfg_data[5:0];
                    fnms_pkg::CFG_QW0:  q_words[0] = i_cfg_data;
                    fnms_pkg::CFG_QW1:  q_words[1] = i_cfg_data;
                    fnms_pkg::CFG_QW2:  q_words[2] = i_cfg_data;
                    fnms_pkg::CFG_QW3:  q_words[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_scores.size() == 0) begin
                    if (o_errors < 10) begin
                        $display("%0t: unexpected result tdata %0h tuser %0d",
                                 $realtime, i_m_tdata, i_m_tuser);
                    end
                    o_errors++;
                end else begin
                    fnms_pkg::t_result r;
                    r = expected_scores.pop_front();
                    if (i_m_tdata !== {1'b0, r.score} || i_m_tuser !== r.kind) begin
                        if (o_errors < 10) begin
                            $display("%0t: score exp %0d kind %0d, got tdata %0h tuser %0d",
                                     $realtime, r.score, r.kind, i_m_tdata, i_m_tuser);
                        end
                        o_errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) take_char(i_s_tdata, i_s_tlast);
            o_outstanding = expected_scores.size();
        end
    end

endmodule

>>> dv/fuzzy_name_match_scorer_tb.sv
// Testbench top for the fuzzy name match scorer: clock, reset, query programming,
// name streams with random gaps and result back-pressure. Depends on fnms_pkg,
// the scorer RTL and fuzzy_name_match_scorer_checker.
`timescale 1ns / 1ps
module fuzzy_name_match_scorer_tb;

    localparam int MAXQ = 32;
    localparam int MAXT = 256;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we   = 1'b0;
    logic [2:0]  cfg_idx  = fnms_pkg::CFG_QLEN;
    logic [63:0] cfg_data = '0;
    int          errors;
    int          outstanding;

    logic [63:0] qword [4];
    logic [5:0]  qlen;
    logic [7:0]  name_q [$];
    bit          m_fire;
    int          rx_hold;
    string       alphabet = "abcABC";

    fuzzy_name_match_scorer #(.MAX_QUERY(MAXQ), .MAX_TARGET(MAXT)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tlast(s_tlast),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    fuzzy_name_match_scorer_checker #(.MAX_QUERY(MAXQ), .MAX_TARGET(MAXT)) u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tlast(s_tlast),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_outstanding(outstanding)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #400000;
        $display("fuzzy_name_match_scorer: mismatch");
        $finish;
    end

    // result side: random stall after each transfer
    always @(posedge clk) m_fire <= m_tvalid && m_tready;

    always @(negedge clk) begin
        if (m_fire) rx_hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] qbyte(input int j);
        return qword[j / 8][(j % 8) * 8 +: 8];
    endfunction

    function automatic int eff_qlen();
        return (qlen > MAXQ) ? MAXQ : int'(qlen);
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return alphabet[$urandom_range(0, 5)];
        if (r == 6) return fnms_pkg::CHAR_SPACE;
        if (r == 7) return $urandom_range(0, 1) ? "z" : "Z";
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] vary_case(input logic [7:0] c);
        if ($urandom_range(0, 1) == 0) return c;
        if (c >= "a" && c <= "z") return c - 8'h20;
        if (c >= "A" && c <= "Z") return c + 8'h20;
        return c;
    endfunction

    task automatic add_char(input logic [7:0] c);
        name_q = {name_q, c};
    endtask

    task automatic push_noise(input int n);
        repeat (n) add_char(pick_char());
    endtask

    task automatic push_query(input int lo, input int hi);
        for (int j = lo; j < hi; j++) add_char(vary_case(qbyte(j)));
    endtask

    task automatic push_text(input string s);
        for (int j = 0; j < s.len(); j++) add_char(s[j]);
    endtask

    task automatic push_fill(input logic [7:0] c, input int n);
        repeat (n) add_char(c);
    endtask

    task automatic send_name();
        bit burst;
        int gap;
        burst = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < name_q.size(); k++) begin
            gap = burst ? 0 : $urandom_range(0, 5);
            repeat (gap) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
            @(negedge clk);
            s_tvalid <= 1'b1;
            s_tdata  <= name_q[k];
            s_tlast  <= (k == name_q.size() - 1);
            do @(posedge clk); while (!s_tready);
        end
        name_q.delete();
    endtask

    task automatic quiesce();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input fnms_pkg::t_cfg_idx idx, input logic [63:0] d);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic program_query(input bit noisy_len);
        logic [63:0] d;
        d = noisy_len ? {$urandom(), $urandom()} : 64'd0;
        write_reg(fnms_pkg::CFG_QLEN, {d[63:6], qlen});
        write_reg(fnms_pkg::CFG_QW0, qword[0]);
        write_reg(fnms_pkg::CFG_QW1, qword[1]);
        write_reg(fnms_pkg::CFG_QW2, qword[2]);
        write_reg(fnms_pkg::CFG_QW3, qword[3]);
    endtask

    task automatic set_text(input string s);
        for (int w = 0; w < 4; w++) qword[w] = {$urandom(), $urandom()};
        for (int j = 0; j < s.len(); j++) qword[j / 8][(j % 8) * 8 +: 8] = s[j];
        qlen = 6'(s.len());
    endtask

    task automatic build_name();
        int ql;
        int sel;
        ql  = eff_qlen();
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            push_noise($urandom_range(20, 50));
            for (int j = 0; j < ql; j++) begin
                push_noise($urandom_range(0, 2));
                add_char(vary_case(qbyte(j)));
            end
        end else if (sel <= 3) begin
            push_query(0, ql);
        end else if (sel <= 5) begin
            push_query(0, ql);
            push_noise($urandom_range(1, 4));
        end else if (sel <= 7) begin
            push_noise($urandom_range(0, 3));
            add_char(fnms_pkg::CHAR_SPACE);
            push_query(0, ql);
            push_noise($urandom_range(0, 2));
        end else if (sel <= 9) begin
            push_noise($urandom_range(1, 3));
            push_query(0, ql);
            push_noise($urandom_range(0, 2));
        end else if (sel <= 12) begin
            for (int j = 0; j < ql; j++) begin
                push_noise($urandom_range(0, 3));
                add_char(vary_case(qbyte(j)));
            end
        end else if (sel <= 14) begin
            push_query(0, $urandom_range(0, ql));
            push_noise($urandom_range(0, 2));
        end else if (sel <= 17) begin
            push_noise($urandom_range(1, 8));
        end else begin
            push_query(0, ql);
            if (ql > 0) name_q[$urandom_range(0, ql - 1)] = pick_char();
        end
        if (name_q.size() == 0) add_char(pick_char());
    endtask

    initial begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // reset query is empty
        push_text("abc");
        send_name();
        name_q = '{8'h00, 8'hFF};
        send_name();
        quiesce();

        set_text("AliZe");
        program_query(1'b0);
        push_text("aLIzE");
        send_name();
        push_text("alizeX");
        send_name();
        push_text("Bo alize");
        send_name();
        push_text("xALIZEy");
        send_name();
        push_text("a-l-i-z-e");
        send_name();
        push_text("alIz");
        send_name();
        push_text("a");
        for (int k = 0; k < 45; k++) add_char((k % 2) ? "[" : "@");
        push_text("lize");
        send_name();
        push_text("zzz`{");
        send_name();
        quiesce();

        // length beyond the query depth
        set_text("abcdefghijklmnopqrstuvwxyzABCDEF");
        qlen = 6'd40;
        program_query(1'b0);
        push_text("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdef");
        send_name();
        quiesce();

        // position saturation
        set_text("ab");
        program_query(1'b0);
        push_fill("x", 256);
        push_text("axb");
        send_name();
        quiesce();

        for (int ph = 0; ph < 4; ph++) begin
            int r;
            r = $urandom_range(0, 9);
            if (r == 0) qlen = 6'd0;
            else if (r == 1) qlen = 6'd1;
            else if (r == 2) qlen = 6'd32;
            else if (r == 3) qlen = 6'($urandom_range(33, 63));
            else qlen = 6'($urandom_range(2, 8));
            for (int w = 0; w < 4; w++) begin
                for (int b = 0; b < 8; b++) qword[w][b * 8 +: 8] = pick_char();
            end
            program_query($urandom_range(0, 1));
            repeat (4) begin
                build_name();
                send_name();
            end
            quiesce();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && outstanding == 0) begin
            $display("fuzzy_name_match_scorer: match");
        end else begin
            $display("fuzzy_name_match_scorer: mismatch");
        end
        $finish;
    end

endmodule
